@@ rtl/njps_pkg.sv @@
// shared types and constants of the nearest joint pose selector
package njps_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_COUNT = 1'b1;

  localparam logic [1:0] OP_TABLE_WRITE = 2'd0;
  localparam logic [1:0] OP_JOINT_WRITE = 2'd1;
  localparam logic [1:0] OP_SELECT      = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic               side;
    logic [3:0]         pose_index;
    logic [2:0]         joint_index;
    logic signed [15:0] angle;
  } cmd_word_t;

  typedef struct packed {
    logic [3:0]  left_pose;
    logic [3:0]  right_pose;
    logic [16:0] left_dist;
    logic [16:0] right_dist;
    logic [18:0] abs_total;
    logic [16:0] norm_total;
    logic [15:0] peak_delta;
  } res_word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

@@ rtl/njps_stream_if.sv @@
// valid/ready channel carrying one word per handshake
interface njps_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/njps_ram.sv @@
// generic single-port ram with registered read
module njps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ rtl/njps_sqrt.sv @@
// iterative floored integer square root, one result bit per cycle
module njps_sqrt #(
  parameter int IN_W = 36
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [IN_W-1:0]          value,
  output njps_pkg::sqrt_stat_t     stat,
  output logic [(IN_W+1)/2-1:0]    root
);
  import njps_pkg::*;

  localparam int RT_W  = (IN_W + 1) / 2;
  localparam int SW    = 2 * RT_W;
  localparam int RM_W  = RT_W + 2;
  localparam int CNT_W = $clog2(RT_W + 1);

  logic [SW-1:0]    val;
  logic [RM_W-1:0]  rem;
  logic [RT_W-1:0]  root_q;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [RM_W-1:0]  rem_sh;
  logic [RM_W-1:0]  trial;
  logic             ge;
  logic [RM_W-1:0]  rem_next;
  logic [RT_W-1:0]  root_next;

  always_comb begin
    rem_sh    = {rem[RT_W-1:0], val[SW-1 -: 2]};
    trial     = {root_q, 2'b01};
    ge        = (rem_sh >= trial);
    rem_next  = ge ? (rem_sh - trial) : rem_sh;
    root_next = {root_q[RT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(RT_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      val    <= SW'(value);
      rem    <= '0;
      root_q <= '0;
    end else if (busy) begin
      val    <= val << 2;
      rem    <= rem_next;
      root_q <= root_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign root      = root_q;

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("root finished without a running extraction");

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("start did not launch the root unit");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("root unit still busy when reporting done");
endmodule

@@ rtl/nearest_joint_pose_selector.sv @@
// top level of the nearest joint pose selector
//
// cmd carries one word per handshake: a table angle write, a current joint
// angle write or a select. res carries one result word per select. Both use
// valid/ready; a word moves at a clock edge where both are high.
// cfg_wen/cfg_index/cfg_wdata write the left and right pose counts, and must
// be used only while the block is idle; the block itself does not enforce it.
// The pose table sits in one ram, one whole pose per word, so a table write
// is a read-modify-write through ST_WR_RD and ST_WR_WB; a joint angle write
// is done at its handshake. A select streams one pose per cycle through a
// four stage distance pipeline, then runs three roots through one shared
// iterative root unit, whose roots are 18 bits wide with the default widths.
// The block returns to idle as the result word is raised, and cmd.ready is
// high only between words.
// A result waits in the output register while the receiver stalls; the next
// word is still taken, and a following select holds in its last step until
// the register is free. Reset clears the current joint angles to zero and
// both counts to one; the pose table is not cleared and must be written first.
module nearest_joint_pose_selector #(
  parameter int MAX_POSES  = 16,
  parameter int JOINTS     = 6,
  parameter int ANGLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  njps_stream_if.sink                     cmd,
  njps_stream_if.source                   res,
  input  logic                            cfg_wen,
  input  logic [njps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [njps_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import njps_pkg::*;

  localparam int AB        = ANGLE_BITS;
  localparam int PIW       = (MAX_POSES > 1) ? $clog2(MAX_POSES) : 1;
  localparam int JIW       = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int AW        = PIW + 1;
  localparam int CMP_W     = $clog2(MAX_POSES + 1) + 5;
  localparam int SQ_ARM_W  = 2 * AB + $clog2(JOINTS);
  localparam int SQ_ALL_W  = SQ_ARM_W + 1;
  localparam int ABS_ARM_W = AB + $clog2(JOINTS);
  localparam int ABS_ALL_W = ABS_ARM_W + 1;
  localparam int RT_W      = (SQ_ALL_W + 1) / 2;
  localparam logic [AB-1:0] HALF = {1'b1, {(AB-1){1'b0}}};

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_WR_RD     = 8'b0000_0010,
    ST_WR_WB     = 8'b0000_0100,
    ST_SCAN      = 8'b0000_1000,
    ST_DRAIN     = 8'b0001_0000,
    ST_ROOT_GO   = 8'b0010_0000,
    ST_ROOT_WAIT = 8'b0100_0000,
    ST_FINISH    = 8'b1000_0000
  } state_t;

  typedef enum logic [1:0] {
    RS_LEFT  = 2'd0,
    RS_RIGHT = 2'd1,
    RS_ALL   = 2'd2
  } root_sel_t;

  state_t    state;
  state_t    state_next;
  root_sel_t root_sel;

  logic [CFG_DATA_W-1:0] left_count;
  logic [CFG_DATA_W-1:0] right_count;
  logic [PIW-1:0]        lim_l;
  logic [PIW-1:0]        lim_r;

  cmd_word_t cmd_q;
  logic      cmd_fire;
  logic      joint_ok;
  logic      pose_ok;
  logic [AB-1:0] angle_in;
  logic [AB-1:0] angle_q;

  logic [AB-1:0] cur [2][JOINTS];

  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  logic [JOINTS*AB-1:0] ram_wdata;
  logic [JOINTS*AB-1:0] ram_rdata;

  logic           scan_arm;
  logic [PIW-1:0] scan_pose;
  logic           scan_last;

  // distance pipeline
  logic           s1_v, s2_v, s3_v, s4_v;
  logic           s1_arm, s2_arm, s3_arm, s4_arm;
  logic [PIW-1:0] s1_pose, s2_pose, s3_pose, s4_pose;
  logic [AB-1:0]  diff1 [JOINTS];
  logic [AB-1:0]  d1 [JOINTS];
  logic [AB-1:0]  s2_d [JOINTS];
  logic [AB-1:0]  s3_d [JOINTS];
  logic [2*AB-1:0] s3_sq [JOINTS];
  logic [SQ_ARM_W-1:0]  sum_sq3;
  logic [ABS_ARM_W-1:0] sum_abs3;
  logic [AB-1:0]        max3;
  logic [SQ_ARM_W-1:0]  s4_sq;
  logic [ABS_ARM_W-1:0] s4_abs;
  logic [AB-1:0]        s4_max;

  logic [SQ_ARM_W-1:0]  best_sq  [2];
  logic [ABS_ARM_W-1:0] best_abs [2];
  logic [AB-1:0]        best_max [2];
  logic [PIW-1:0]       best_idx [2];

  logic                 sq_start;
  logic [SQ_ALL_W-1:0]  sq_value;
  sqrt_stat_t           sq_stat;
  logic [RT_W-1:0]      sq_root;
  logic [RT_W-1:0]      dist_l, dist_r, dist_all;
  logic [ABS_ALL_W-1:0] abs_all;
  logic [AB-1:0]        max_all;
  logic                 res_load;

  function automatic logic [PIW-1:0] clamp_lim(input logic [CFG_DATA_W-1:0] c);
    logic [CMP_W-1:0] ce;
    logic [PIW-1:0]   r;
    ce = CMP_W'(c);
    if (ce == '0) begin
      r = '0;
    end else if (ce > CMP_W'(MAX_POSES)) begin
      r = PIW'(MAX_POSES - 1);
    end else begin
      r = PIW'(ce - 1'b1);
    end
    return r;
  endfunction

  function automatic logic [AB-1:0] to_angle(input logic [15:0] raw);
    return AB'(raw);
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      left_count  <= CFG_DATA_W'(1);
      right_count <= CFG_DATA_W'(1);
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_LEFT_COUNT:  left_count  <= cfg_wdata;
        CFG_RIGHT_COUNT: right_count <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign lim_l = clamp_lim(left_count);
  assign lim_r = clamp_lim(right_count);

  // command intake
  assign cmd.ready = (state == ST_IDLE);
  assign cmd_fire  = cmd.valid && (state == ST_IDLE);
  assign joint_ok  = ({1'b0, cmd.payload.joint_index} < 4'(JOINTS));
  assign pose_ok   = (CMP_W'(cmd.payload.pose_index) < CMP_W'(MAX_POSES));
  assign angle_in  = to_angle(cmd.payload.angle);
  assign angle_q   = to_angle(cmd_q.angle);

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      cmd_q <= cmd.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 2; a++) begin
        for (int j = 0; j < JOINTS; j++) begin
          cur[a][j] <= '0;
        end
      end
    end else if (cmd_fire && cmd.payload.operation == OP_JOINT_WRITE && joint_ok) begin
      cur[cmd.payload.side][JIW'(cmd.payload.joint_index)] <= angle_in;
    end
  end

  // control
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_fire) begin
          if (cmd.payload.operation == OP_TABLE_WRITE && joint_ok && pose_ok) begin
            state_next = ST_WR_RD;
          end else if (cmd.payload.operation == OP_SELECT) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_WR_RD:  state_next = ST_WR_WB;
      ST_WR_WB:  state_next = ST_IDLE;
      ST_SCAN: begin
        if (scan_last && scan_arm) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!(s1_v || s2_v || s3_v || s4_v)) begin
          state_next = ST_ROOT_GO;
        end
      end
      ST_ROOT_GO: state_next = ST_ROOT_WAIT;
      ST_ROOT_WAIT: begin
        if (sq_stat.done) begin
          state_next = (root_sel == RS_ALL) ? ST_FINISH : ST_ROOT_GO;
        end
      end
      ST_FINISH: begin
        if (res_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // pose scan
  assign scan_last = (scan_pose == (scan_arm ? lim_r : lim_l));

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_arm  <= 1'b0;
      scan_pose <= '0;
    end else if (state == ST_IDLE) begin
      scan_arm  <= 1'b0;
      scan_pose <= '0;
    end else if (state == ST_SCAN) begin
      if (scan_last) begin
        scan_arm  <= 1'b1;
        scan_pose <= '0;
      end else begin
        scan_pose <= scan_pose + 1'b1;
      end
    end
  end

  // pose table
  always_comb begin
    ram_we   = (state == ST_WR_WB);
    ram_addr = (state == ST_SCAN) ? {scan_arm, scan_pose}
                                  : {cmd_q.side, PIW'(cmd_q.pose_index)};
    for (int j = 0; j < JOINTS; j++) begin
      ram_wdata[j*AB +: AB] = (JIW'(cmd_q.joint_index) == JIW'(j)) ? angle_q
                                                                   : ram_rdata[j*AB +: AB];
    end
  end

  njps_ram #(
    .WIDTH (JOINTS * AB),
    .DEPTH (2 ** AW)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // wrapped differences
  always_comb begin
    for (int j = 0; j < JOINTS; j++) begin
      diff1[j] = ram_rdata[j*AB +: AB] - cur[s1_arm][j];
      d1[j]    = (diff1[j] > HALF) ? (AB'(0) - diff1[j]) : diff1[j];
    end
  end

  always_comb begin
    sum_sq3  = '0;
    sum_abs3 = '0;
    max3     = '0;
    for (int j = 0; j < JOINTS; j++) begin
      sum_sq3  = sum_sq3 + SQ_ARM_W'(s3_sq[j]);
      sum_abs3 = sum_abs3 + ABS_ARM_W'(s3_d[j]);
      if (s3_d[j] > max3) begin
        max3 = s3_d[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else begin
      s1_v <= (state == ST_SCAN);
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_arm  <= scan_arm;
    s1_pose <= scan_pose;
    s2_arm  <= s1_arm;
    s2_pose <= s1_pose;
    s3_arm  <= s2_arm;
    s3_pose <= s2_pose;
    s4_arm  <= s3_arm;
    s4_pose <= s3_pose;
    for (int j = 0; j < JOINTS; j++) begin
      s2_d[j]  <= d1[j];
      s3_d[j]  <= s2_d[j];
      s3_sq[j] <= s2_d[j] * s2_d[j];
    end
    s4_sq  <= sum_sq3;
    s4_abs <= sum_abs3;
    s4_max <= max3;
  end

  // nearest pose per arm, lowest index wins a tie
  always_ff @(posedge clk) begin
    if (s4_v && ((s4_pose == '0) || (s4_sq < best_sq[s4_arm]))) begin
      best_sq[s4_arm]  <= s4_sq;
      best_abs[s4_arm] <= s4_abs;
      best_max[s4_arm] <= s4_max;
      best_idx[s4_arm] <= s4_pose;
    end
  end

  // roots
  assign sq_start = (state == ST_ROOT_GO);

  always_comb begin
    case (root_sel)
      RS_LEFT:  sq_value = SQ_ALL_W'(best_sq[0]);
      RS_RIGHT: sq_value = SQ_ALL_W'(best_sq[1]);
      RS_ALL:   sq_value = SQ_ALL_W'(best_sq[0]) + SQ_ALL_W'(best_sq[1]);
      default:  sq_value = '0;
    endcase
  end

  njps_sqrt #(
    .IN_W (SQ_ALL_W)
  ) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (sq_value),
    .stat  (sq_stat),
    .root  (sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      root_sel <= RS_LEFT;
    end else if (state == ST_DRAIN) begin
      root_sel <= RS_LEFT;
    end else if (state == ST_ROOT_WAIT && sq_stat.done) begin
      case (root_sel)
        RS_LEFT:  root_sel <= RS_RIGHT;
        RS_RIGHT: root_sel <= RS_ALL;
        default:  root_sel <= RS_LEFT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_ROOT_WAIT && sq_stat.done) begin
      case (root_sel)
        RS_LEFT:  dist_l   <= sq_root;
        RS_RIGHT: dist_r   <= sq_root;
        default:  dist_all <= sq_root;
      endcase
    end
  end

  // result word
  assign abs_all  = ABS_ALL_W'(best_abs[0]) + ABS_ALL_W'(best_abs[1]);
  assign max_all  = (best_max[1] > best_max[0]) ? best_max[1] : best_max[0];
  assign res_load = (state == ST_FINISH) && (!res.valid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (res_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res.payload.left_pose  <= 4'(best_idx[0]);
      res.payload.right_pose <= 4'(best_idx[1]);
      res.payload.left_dist  <= 17'(dist_l);
      res.payload.right_dist <= 17'(dist_r);
      res.payload.abs_total  <= 19'(abs_all);
      res.payload.norm_total <= 17'(dist_all);
      res.payload.peak_delta <= 16'(max_all);
    end
  end

  a_wb_after_rd: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WR_WB) |-> $past(state == ST_WR_RD))
    else $error("table write-back without its read");

  a_res_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(state == ST_FINISH))
    else $error("result word raised outside the final step");

  a_pipe_in_scan: assert property (@(posedge clk) disable iff (rst)
    s4_v |-> (state == ST_SCAN || state == ST_DRAIN))
    else $error("distance pipeline busy outside a scan");

  a_best_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |-> (best_idx[0] <= lim_l && best_idx[1] <= lim_r))
    else $error("chosen pose beyond the poses in use");
endmodule
